// ----- rtl/core/pcpe_pkg.sv -----
// ----------------------------------------------------------------------------
// pcpe_pkg: shared types and constants of the curve point evaluator
// Item types, register indexes, commands, and the fixed-point constants for
// range reduction, the rotation unit and output saturation.
// ----------------------------------------------------------------------------
package pcpe_pkg;

	typedef struct packed {
		logic              command;
		logic signed [31:0] angle;
	} pcpe_in_t;

	typedef struct packed {
		logic signed [47:0] out_x;
		logic signed [47:0] out_y;
		logic signed [47:0] out_z;
	} pcpe_out_t;

	typedef struct packed {
		logic              command;
		logic signed [31:0] angle;
		logic [1:0]        quad;
	} pcpe_side_t;

	localparam logic [1:0] REG_RADIUS_X = 2'd0;
	localparam logic [1:0] REG_RADIUS_Y = 2'd1;
	localparam logic [1:0] REG_PITCH    = 2'd2;

	localparam logic CMD_POINT = 1'b0;
	localparam logic CMD_DERIV = 1'b1;

	localparam logic [31:0] TWO_OVER_PI = 32'hA2F9836E;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic signed [32:0] GAIN_INV_Q30 = 33'sd652032874;

	localparam logic signed [63:0] TRIG_HALF  = 64'sd536870912;
	localparam int                 TRIG_SHIFT = 30;

	localparam logic signed [63:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] OUT_MIN = -64'sh0000_8000_0000_0000;

	localparam logic [29:0] ATAN_Q30 [32] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
		30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
		30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
		30'd262144,    30'd131072,    30'd65536,     30'd32768,
		30'd16384,     30'd8192,      30'd4096,      30'd2048,
		30'd1024,      30'd512,       30'd256,       30'd128,
		30'd64,        30'd32,        30'd16,        30'd8,
		30'd4,         30'd2,         30'd1,         30'd0
	};

	function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
		logic signed [47:0] r;
		if (v > OUT_MAX) begin
			r = OUT_MAX[47:0];
		end else if (v < OUT_MIN) begin
			r = OUT_MIN[47:0];
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/pcpe_reduce.sv -----
// ----------------------------------------------------------------------------
// pcpe_reduce: range reduction of the curve parameter
// Three stages: magnitude, multiply by 2/pi into quadrant and fraction,
// then scale the fraction by pi/2 into the Q2.30 residual angle.
// ----------------------------------------------------------------------------
module pcpe_reduce #(
	parameter int FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    src_valid,
	output logic                    src_ready,
	input  pcpe_pkg::pcpe_in_t      src_item,
	output logic                    dst_valid,
	input  logic                    dst_ready,
	output logic signed [32:0]      dst_z0,
	output pcpe_pkg::pcpe_side_t    dst_side
);

	logic                  v_s1, v_s2, v_s3;
	logic                  r1, r2, r3;
	pcpe_pkg::pcpe_in_t    item_s1;
	logic [31:0]           mag_s1;
	pcpe_pkg::pcpe_side_t  side_s2, side_s3;
	logic [31:0]           frac_s2;
	logic [30:0]           z0_s3;
	logic [31:0]           mag_w;
	logic [63:0]           prod1_w, prod2_w;
	pcpe_pkg::pcpe_side_t  side_w;

	assign r3 = !v_s3 || dst_ready;
	assign r2 = !v_s2 || r3;
	assign r1 = !v_s1 || r2;
	assign src_ready = r1;

	assign mag_w = src_item.angle[31] ? (~src_item.angle + 32'd1) : src_item.angle;

	assign prod1_w = {32'b0, mag_s1} * {32'b0, pcpe_pkg::TWO_OVER_PI};
	assign prod2_w = {32'b0, frac_s2} * {33'b0, pcpe_pkg::HALF_PI_Q30};

	always_comb begin
		side_w.command = item_s1.command;
		side_w.angle   = item_s1.angle;
		side_w.quad    = prod1_w[FRAC_BITS+33:FRAC_BITS+32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (r1) v_s1 <= src_valid;
			if (r2) v_s2 <= v_s1;
			if (r3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (r1 && src_valid) begin
			item_s1 <= src_item;
			mag_s1  <= mag_w;
		end
		if (r2 && v_s1) begin
			side_s2 <= side_w;
			frac_s2 <= prod1_w[FRAC_BITS+31:FRAC_BITS];
		end
		if (r3 && v_s2) begin
			side_s3 <= side_s2;
			z0_s3   <= prod2_w[62:32];
		end
	end

	assign dst_valid = v_s3;
	assign dst_z0    = signed'({2'b00, z0_s3});
	assign dst_side  = side_s3;

	a_z0_below_half_pi: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (z0_s3 < pcpe_pkg::HALF_PI_Q30))
		else $error("residual angle not below pi/2");

	a_held_item_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !r2) |=> v_s2)
		else $error("held item dropped in reduction");

endmodule

// ----- rtl/core/pcpe_cordic.sv -----
// ----------------------------------------------------------------------------
// pcpe_cordic: pipelined circular rotation
// One register stage per rotation step; gives cosine and sine in Q2.30 for
// a residual angle in the first quarter turn.
// ----------------------------------------------------------------------------
module pcpe_cordic #(
	parameter int ROTATION_STEPS = 18
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    src_valid,
	output logic                    src_ready,
	input  logic signed [32:0]      src_z0,
	input  pcpe_pkg::pcpe_side_t    src_side,
	output logic                    dst_valid,
	input  logic                    dst_ready,
	output logic signed [32:0]      dst_cos,
	output logic signed [32:0]      dst_sin,
	output pcpe_pkg::pcpe_side_t    dst_side
);

	localparam int N = ROTATION_STEPS;

	logic [N-1:0]          v_s;
	wire  [N-1:0]          rdy;
	logic signed [32:0]    x_s [N];
	logic signed [32:0]    y_s [N];
	logic signed [32:0]    z_s [N];
	pcpe_pkg::pcpe_side_t  side_s [N];

	for (genvar i = 0; i < N; i++) begin : g_step
		logic signed [32:0]   x_in, y_in, z_in, dx, dy, x_nx, y_nx, z_nx, ang;
		logic                 v_in, dir;
		pcpe_pkg::pcpe_side_t sd_in;

		if (i == 0) begin : g_first
			assign x_in  = pcpe_pkg::GAIN_INV_Q30;
			assign y_in  = '0;
			assign z_in  = src_z0;
			assign v_in  = src_valid;
			assign sd_in = src_side;
		end else begin : g_next
			assign x_in  = x_s[i-1];
			assign y_in  = y_s[i-1];
			assign z_in  = z_s[i-1];
			assign v_in  = v_s[i-1];
			assign sd_in = side_s[i-1];
		end

		if (i == N - 1) begin : g_last_rdy
			assign rdy[i] = !v_s[i] || dst_ready;
		end else begin : g_mid_rdy
			assign rdy[i] = !v_s[i] || rdy[i+1];
		end

		assign ang  = signed'({3'b000, pcpe_pkg::ATAN_Q30[i]});
		assign dir  = !z_in[32];
		assign dx   = y_in >>> i;
		assign dy   = x_in >>> i;
		assign x_nx = dir ? (x_in - dx) : (x_in + dx);
		assign y_nx = dir ? (y_in + dy) : (y_in - dy);
		assign z_nx = dir ? (z_in - ang) : (z_in + ang);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (rdy[i]) begin
				v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i] && v_in) begin
				x_s[i]    <= x_nx;
				y_s[i]    <= y_nx;
				z_s[i]    <= z_nx;
				side_s[i] <= sd_in;
			end
		end
	end

	assign src_ready = rdy[0];
	assign dst_valid = v_s[N-1];
	assign dst_cos   = x_s[N-1];
	assign dst_sin   = y_s[N-1];
	assign dst_side  = side_s[N-1];

	a_rotation_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[N-1] |-> ((x_s[N-1][32] == x_s[N-1][31]) && (y_s[N-1][32] == y_s[N-1][31])))
		else $error("rotation result outside Q2.30 range");

endmodule

// ----- rtl/core/pcpe_scale.sv -----
// ----------------------------------------------------------------------------
// pcpe_scale: quadrant mapping, radius and pitch scaling, output register
// Maps the rotation result to the quadrant, picks point or derivative terms,
// multiplies by the radii and pitch, then rounds and saturates to Q32.16.
// ----------------------------------------------------------------------------
module pcpe_scale #(
	parameter int FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    src_valid,
	output logic                    src_ready,
	input  logic signed [32:0]      src_cos,
	input  logic signed [32:0]      src_sin,
	input  pcpe_pkg::pcpe_side_t    src_side,
	input  logic [30:0]             radius_x,
	input  logic [30:0]             radius_y,
	input  logic signed [31:0]      pitch,
	output logic                    dst_valid,
	input  logic                    dst_ready,
	output pcpe_pkg::pcpe_out_t     dst_item
);

	localparam logic signed [63:0] Z_HALF = 64'sd1 <<< (FRAC_BITS - 1);

	logic                  v_s1, v_s2, v_s3;
	logic                  r1, r2, r3;
	logic signed [32:0]    tx_s1, ty_s1;
	logic                  cmd_s1, cmd_s2;
	logic signed [31:0]    angle_s1;
	logic signed [63:0]    px_s2, py_s2, pz_s2;
	pcpe_pkg::pcpe_out_t   result_s3;

	logic signed [32:0]    c_w, s_w, sn_w, tx_w, ty_w;
	logic signed [31:0]    rxs_w, rys_w;
	logic signed [63:0]    px_w, py_w, pz_w, xr_w, yr_w, zr_w;
	pcpe_pkg::pcpe_out_t   result_w;

	assign r3 = !v_s3 || dst_ready;
	assign r2 = !v_s2 || r3;
	assign r1 = !v_s1 || r2;
	assign src_ready = r1;

	always_comb begin
		unique case (src_side.quad)
			2'd0: begin c_w = src_cos;  s_w = src_sin;  end
			2'd1: begin c_w = -src_sin; s_w = src_cos;  end
			2'd2: begin c_w = -src_cos; s_w = -src_sin; end
			2'd3: begin c_w = src_sin;  s_w = -src_cos; end
		endcase
		sn_w = src_side.angle[31] ? -s_w : s_w;
		if (src_side.command == pcpe_pkg::CMD_DERIV) begin
			tx_w = -sn_w;
			ty_w = c_w;
		end else begin
			tx_w = c_w;
			ty_w = sn_w;
		end
	end

	assign rxs_w = signed'({1'b0, radius_x});
	assign rys_w = signed'({1'b0, radius_y});
	assign px_w  = rxs_w * tx_s1;
	assign py_w  = rys_w * ty_s1;
	assign pz_w  = pitch * angle_s1;

	assign xr_w = (px_s2 + pcpe_pkg::TRIG_HALF) >>> pcpe_pkg::TRIG_SHIFT;
	assign yr_w = (py_s2 + pcpe_pkg::TRIG_HALF) >>> pcpe_pkg::TRIG_SHIFT;
	assign zr_w = (pz_s2 + Z_HALF) >>> FRAC_BITS;

	always_comb begin
		result_w.out_x = pcpe_pkg::sat48(xr_w);
		result_w.out_y = pcpe_pkg::sat48(yr_w);
		if (cmd_s2 == pcpe_pkg::CMD_DERIV) begin
			result_w.out_z = {{16{pitch[31]}}, pitch};
		end else begin
			result_w.out_z = pcpe_pkg::sat48(zr_w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (r1) v_s1 <= src_valid;
			if (r2) v_s2 <= v_s1;
			if (r3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (r1 && src_valid) begin
			tx_s1    <= tx_w;
			ty_s1    <= ty_w;
			cmd_s1   <= src_side.command;
			angle_s1 <= src_side.angle;
		end
		if (r2 && v_s1) begin
			px_s2  <= px_w;
			py_s2  <= py_w;
			pz_s2  <= pz_w;
			cmd_s2 <= cmd_s1;
		end
		if (r3 && v_s2) begin
			result_s3 <= result_w;
		end
	end

	assign dst_valid = v_s3;
	assign dst_item  = result_s3;

	a_trig_terms_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (($countones(result_s3.out_x[47:32]) == 0 ||
			$countones(result_s3.out_x[47:32]) == 16) &&
			($countones(result_s3.out_y[47:32]) == 0 ||
			$countones(result_s3.out_y[47:32]) == 16)))
		else $error("scaled trig term beyond radius range");

endmodule

// ----- rtl/core/parametric_curve_point_eval.sv -----
// Throughput: one item per cycle unless a stalled result holds the stages.
// The rotation unit has one register stage per step.
// A stalled result holds a stage only where no empty stage remains downstream of it.
// Reset clears all stage valid bits; radius_x and radius_y reset to 1.0, pitch to 0.
// ----------------------------------------------------------------------------
// parametric_curve_point_eval: ellipse, circle and helix point and tangent
// Evaluates (rx cos t, ry sin t, pitch t) or its first derivative per item
// in Q16.16 with saturated Q32.16 results.
// ----------------------------------------------------------------------------
module parametric_curve_point_eval #(
	parameter int ROTATION_STEPS = 18,
	parameter int FRAC_BITS      = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  pcpe_pkg::pcpe_in_t   sample,
	output logic                 result_valid,
	input  logic                 result_stall,
	output pcpe_pkg::pcpe_out_t  result,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_wdata
);

	localparam logic [30:0] ONE_Q = 31'(1) << FRAC_BITS;

	logic [30:0]           radius_x_q, radius_y_q;
	logic signed [31:0]    pitch_q;

	logic                  red_ready, red_valid;
	logic signed [32:0]    red_z0;
	pcpe_pkg::pcpe_side_t  red_side;
	logic                  rot_ready, rot_valid;
	logic signed [32:0]    rot_cos, rot_sin;
	pcpe_pkg::pcpe_side_t  rot_side;
	logic                  scl_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_x_q <= ONE_Q;
			radius_y_q <= ONE_Q;
			pitch_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pcpe_pkg::REG_RADIUS_X: radius_x_q <= cfg_wdata[30:0];
				pcpe_pkg::REG_RADIUS_Y: radius_y_q <= cfg_wdata[30:0];
				pcpe_pkg::REG_PITCH:    pitch_q    <= signed'(cfg_wdata);
				default: begin
				end
			endcase
		end
	end

	pcpe_reduce #(
		.FRAC_BITS(FRAC_BITS)
	) u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (sample_valid),
		.src_ready (red_ready),
		.src_item  (sample),
		.dst_valid (red_valid),
		.dst_ready (rot_ready),
		.dst_z0    (red_z0),
		.dst_side  (red_side)
	);

	pcpe_cordic #(
		.ROTATION_STEPS(ROTATION_STEPS)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (red_valid),
		.src_ready (rot_ready),
		.src_z0    (red_z0),
		.src_side  (red_side),
		.dst_valid (rot_valid),
		.dst_ready (scl_ready),
		.dst_cos   (rot_cos),
		.dst_sin   (rot_sin),
		.dst_side  (rot_side)
	);

	pcpe_scale #(
		.FRAC_BITS(FRAC_BITS)
	) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (rot_valid),
		.src_ready (scl_ready),
		.src_cos   (rot_cos),
		.src_sin   (rot_sin),
		.src_side  (rot_side),
		.radius_x  (radius_x_q),
		.radius_y  (radius_y_q),
		.pitch     (pitch_q),
		.dst_valid (result_valid),
		.dst_ready (!result_stall),
		.dst_item  (result)
	);

	assign sample_stall = !red_ready;

endmodule
